>>> hw/rtl/countdown_timer_with_set_mode_unit_macros.svh
// Assertion macros for the countdown timer unit checker.
// Expects signals named clk and arst_n in the scope of use.
`ifndef COUNTDOWN_TIMER_WITH_SET_MODE_UNIT_MACROS_SVH
`define COUNTDOWN_TIMER_WITH_SET_MODE_UNIT_MACROS_SVH

// same-cycle implication
`define CDT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cdt_pkg.sv
// Shared types and constants for the countdown timer unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps

package cdt_pkg;

	localparam int SEC_W       = 16;
	localparam int TICK_W      = 16;
	localparam int STEP_W      = 6;
	localparam int JUMP_W      = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;

	localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(15625);
	localparam logic [STEP_W-1:0] COUNT_STEP_RESET = STEP_W'(1);
	localparam logic [JUMP_W-1:0] JUMP_STEP_RESET = JUMP_W'(10);
	localparam logic [SEC_W-1:0]  MIN_RESET = SEC_W'(0);
	localparam logic [SEC_W-1:0]  MAX_RESET = SEC_W'(5999);
	localparam logic [SEC_W-1:0]  START_RESET = SEC_W'(60);

	typedef enum logic [IN_TUSER_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_DOWN   = 2'd1,
		KIND_UP     = 2'd2,
		KIND_BUTTON = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICKS      = 3'd0,
		REG_COUNT_STEP = 3'd1,
		REG_JUMP_STEP  = 3'd2,
		REG_MIN        = 3'd3,
		REG_MAX        = 3'd4,
		REG_START      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [TICK_W-1:0] ticks_per_second;
		logic [STEP_W-1:0] count_step;
		logic [JUMP_W-1:0] jump_step;
		logic [SEC_W-1:0]  min_seconds;
		logic [SEC_W-1:0]  max_seconds;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic  other_phase;
		logic  reset_button;
		logic  pause_button;
		logic  set_button;
	} item_t;

	typedef struct packed {
		logic [SEC_W-1:0] shown_seconds;
		logic             running;
		logic             finished;
		logic             set_mode;
	} result_t;

endpackage

>>> hw/rtl/countdown_timer_with_set_mode_unit.sv
// Countdown timer with set mode: input register, timer core, result register.
// Pipeline: a request accepted into the input register passes through the timer
// core into the result register, which drives m_tdata until m_tready takes it.
// Throughput: one request per cycle unless m_tready stalls the output.
// Reset: arst_n clears both stages, loads count and target with 60 seconds,
// and returns all configuration registers to their defaults.
`timescale 1ns / 1ps

module countdown_timer_with_set_mode_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] other_phase, [1] reset_button, [2] pause_button, [3] set_button
	input  logic [cdt_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] kind
	input  logic [cdt_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] shown_seconds, [16] running, [17] finished, [18] set_mode
	output logic [cdt_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [cdt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cdt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	cdt_pkg::cfg_t    cfg;
	cdt_pkg::item_t   item_s1;
	logic             valid_s1;
	cdt_pkg::result_t result;
	cdt_pkg::result_t out_q;
	logic             out_valid_q;
	logic             advance;

	cdt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind         <= cdt_pkg::kind_t'(s_tuser);
			item_s1.other_phase  <= s_tdata[0];
			item_s1.reset_button <= s_tdata[1];
			item_s1.pause_button <= s_tdata[2];
			item_s1.set_button   <= s_tdata[3];
		end
	end

	cdt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.set_mode, out_q.finished, out_q.running, out_q.shown_seconds};

endmodule

>>> hw/rtl/cdt_cfg.sv
// Configuration register file of the countdown timer unit.
// Depends on cdt_pkg.
`timescale 1ns / 1ps

module cdt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data,
	output cdt_pkg::cfg_t                  cfg
);

	cdt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= cdt_pkg::TICKS_RESET;
			cfg_q.count_step       <= cdt_pkg::COUNT_STEP_RESET;
			cfg_q.jump_step        <= cdt_pkg::JUMP_STEP_RESET;
			cfg_q.min_seconds      <= cdt_pkg::MIN_RESET;
			cfg_q.max_seconds      <= cdt_pkg::MAX_RESET;
		end else if (cfg_we) begin
			unique case (cdt_pkg::cfg_reg_t'(cfg_index))
				cdt_pkg::REG_TICKS:      cfg_q.ticks_per_second <= cfg_data[cdt_pkg::TICK_W-1:0];
				cdt_pkg::REG_COUNT_STEP: cfg_q.count_step <= cfg_data[cdt_pkg::STEP_W-1:0];
				cdt_pkg::REG_JUMP_STEP:  cfg_q.jump_step <= cfg_data[cdt_pkg::JUMP_W-1:0];
				cdt_pkg::REG_MIN:        cfg_q.min_seconds <= cfg_data[cdt_pkg::SEC_W-1:0];
				cdt_pkg::REG_MAX:        cfg_q.max_seconds <= cfg_data[cdt_pkg::SEC_W-1:0];
				// start value takes effect only through reset
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/cdt_core.sv
// Timer state and its combinational update for one request.
// Depends on cdt_pkg.
`timescale 1ns / 1ps

module cdt_core (
	input  logic            clk,
	input  logic            arst_n,
	input  cdt_pkg::cfg_t   cfg,
	input  logic            advance,
	input  cdt_pkg::item_t  item,
	output cdt_pkg::result_t result
);

	logic [cdt_pkg::SEC_W-1:0]  remaining_q, target_q;
	logic [cdt_pkg::TICK_W-1:0] tick_q;
	logic                       run_q, done_q, mode_q;
	logic [2:0]                 seen_q;

	logic [cdt_pkg::SEC_W-1:0]  rem_n, target_n;
	logic [cdt_pkg::TICK_W-1:0] tick_n;
	logic                       run_n, done_n, mode_n;
	logic [2:0]                 seen_n;

	logic [cdt_pkg::TICK_W-1:0] period;
	logic [cdt_pkg::TICK_W:0]   tick_inc;
	logic [cdt_pkg::SEC_W-1:0]  step_ext;
	logic [cdt_pkg::SEC_W-1:0]  rem_dec;
	logic [cdt_pkg::SEC_W:0]    jump_ext;
	logic [cdt_pkg::SEC_W:0]    down_diff, up_sum;
	logic                       down_low, up_high;
	logic                       qualified;
	logic                       reset_edge, pause_edge, set_edge;

	always_comb begin
		period    = (cfg.ticks_per_second == '0) ? cdt_pkg::TICK_W'(1) : cfg.ticks_per_second;
		tick_inc  = {1'b0, tick_q} + (cdt_pkg::TICK_W + 1)'(1);
		step_ext  = cdt_pkg::SEC_W'(cfg.count_step);
		rem_dec   = (remaining_q > step_ext) ? (remaining_q - step_ext) : '0;
		jump_ext  = (cdt_pkg::SEC_W + 1)'(cfg.jump_step);
		down_diff = {1'b0, target_q} - jump_ext;
		down_low  = ({1'b0, target_q} < jump_ext)
			|| (down_diff[cdt_pkg::SEC_W-1:0] < cfg.min_seconds);
		up_sum    = {1'b0, target_q} + jump_ext;
		up_high   = up_sum > {1'b0, cfg.max_seconds};
		qualified = item.other_phase && mode_q;
		reset_edge = item.reset_button && !seen_q[0];
		pause_edge = item.pause_button && !seen_q[1];
		set_edge   = item.set_button && !seen_q[2];

		rem_n    = remaining_q;
		target_n = target_q;
		tick_n   = tick_q;
		run_n    = run_q;
		done_n   = done_q;
		mode_n   = mode_q;
		seen_n   = seen_q;

		unique case (item.kind)
			cdt_pkg::KIND_TICK: begin
				if (tick_inc >= {1'b0, period}) begin
					tick_n = '0;
					if (run_q)
						rem_n = rem_dec;
					if (rem_n == '0) begin
						done_n = 1'b1;
						run_n  = 1'b0;
					end
				end else begin
					tick_n = tick_inc[cdt_pkg::TICK_W-1:0];
				end
			end
			cdt_pkg::KIND_DOWN: begin
				if (qualified)
					target_n = down_low ? cfg.min_seconds : down_diff[cdt_pkg::SEC_W-1:0];
			end
			cdt_pkg::KIND_UP: begin
				if (qualified)
					target_n = up_high ? cfg.max_seconds : up_sum[cdt_pkg::SEC_W-1:0];
			end
			cdt_pkg::KIND_BUTTON: begin
				seen_n = {item.set_button, item.pause_button, item.reset_button};
				if (reset_edge) begin
					rem_n  = target_q;
					tick_n = '0;
					run_n  = 1'b0;
					done_n = 1'b0;
				end
				if (pause_edge) begin
					if (!run_n)
						tick_n = '0;
					run_n = !run_n;
				end
				if (set_edge)
					mode_n = !mode_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= cdt_pkg::START_RESET;
			target_q    <= cdt_pkg::START_RESET;
			tick_q      <= '0;
			run_q       <= 1'b0;
			done_q      <= 1'b0;
			mode_q      <= 1'b0;
			seen_q      <= '0;
		end else if (advance) begin
			remaining_q <= rem_n;
			target_q    <= target_n;
			tick_q      <= tick_n;
			run_q       <= run_n;
			done_q      <= done_n;
			mode_q      <= mode_n;
			seen_q      <= seen_n;
		end
	end

	assign result.shown_seconds = mode_n ? target_n : rem_n;
	assign result.running       = run_n;
	assign result.finished      = done_n;
	assign result.set_mode      = mode_n;

endmodule

>>> hw/rtl/cdt_checker.sv
// Port-level checker for the countdown timer unit, bound to the top level.
// Depends on countdown_timer_with_set_mode_unit_macros.svh and cdt_pkg.
`timescale 1ns / 1ps
`include "countdown_timer_with_set_mode_unit_macros.svh"

module cdt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cdt_pkg::OUT_TDATA_W-1:0] m_tdata
);

	`CDT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`CDT_ASSERT_NOW(a_rose_after_request, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without request two cycles before")
	`CDT_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled while output empty")

endmodule

bind countdown_timer_with_set_mode_unit cdt_checker u_cdt_checker (.*);
